/* rtl/spf_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the serial port byte fifos
// no dependencies

package spf_pkg;

   localparam int BYTE_W = 8;
   localparam int WORD_W = 16;
   localparam int LINES_W = 11;

   localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
   localparam logic [WORD_W-1:0] NEWLINE_WORD = 16'h000A;
   localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

   typedef enum logic [1:0] {
      FUNC_CPU_READ   = 2'd0,
      FUNC_CPU_WRITE  = 2'd1,
      FUNC_HOST_SEND  = 2'd2,
      FUNC_HOST_DRAIN = 2'd3
   } func_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      func_type            func;
      logic                word_access;
      logic [WORD_W-1:0]   write_value;
      logic [BYTE_W-1:0]   host_byte;
      logic                host_end_of_message;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]   read_data;
      logic [BYTE_W-1:0]   drained_byte;
      logic                drained_valid;
      logic                drained_line_end;
      logic [LINES_W-1:0]  lines_waiting;
      logic                write_dropped;
   } rsp_type;

endpackage

/* rtl/serial_port_byte_word_fifos.sv */
`timescale 1ns / 1ps
// serial port with receive and transmit byte fifos and a pending line count
// uses spf_pkg and two spf_byte_ram instances

// Start is taken when busy is low, busy is high for the one execute cycle that
// follows, and the result strobe rsp_valid is high for one cycle right after
// it, in which the next start is already taken. The pace is set by the single
// write port of each byte memory: a word write or a host byte with its newline
// puts its second byte in during the execute cycle, and read data from the
// memories arrives in that cycle too. The result cannot be held off; it must
// be captured in its strobe cycle. No clearing pass follows reset.
// FIFO_DEPTH may be any value from 4 up.

module serial_port_byte_word_fifos #(
   parameter int FIFO_DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  spf_pkg::req_type req_data,
   output logic             rsp_valid,
   output spf_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(FIFO_DEPTH);
   localparam int FW = $clog2(FIFO_DEPTH + 1);
   localparam logic [AW-1:0] ADDR_LAST = AW'(FIFO_DEPTH - 1);
   localparam logic [FW-1:0] FILL_FULL = FW'(FIFO_DEPTH);
   localparam logic [FW-1:0] FILL_FULL_M1 = FW'(FIFO_DEPTH - 1);
   localparam logic [FW-1:0] FILL_ONE = FW'(1);
   localparam logic [FW-1:0] FILL_TWO = FW'(2);

   function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
      return (a == ADDR_LAST) ? '0 : a + AW'(1);
   endfunction

   spf_pkg::state_type state_ff, state_in;

   logic [AW-1:0] rx_head_ff, rx_head_in;
   logic [AW-1:0] rx_tail_ff, rx_tail_in;
   logic [FW-1:0] rx_fill_ff, rx_fill_in;
   logic [AW-1:0] tx_head_ff, tx_head_in;
   logic [AW-1:0] tx_tail_ff, tx_tail_in;
   logic [FW-1:0] tx_fill_ff, tx_fill_in;
   logic [FW-1:0] line_cnt_ff, line_cnt_in;

   logic pop_lo_ff, pop_lo_in;
   logic pop_hi_ff, pop_hi_in;
   logic drain_ff, drain_in;
   logic dropped_ff, dropped_in;
   logic wr2_en_ff, wr2_en_in;
   logic wr2_tx_ff, wr2_tx_in;
   logic [AW-1:0] wr2_addr_ff, wr2_addr_in;
   logic [spf_pkg::BYTE_W-1:0] wr2_data_ff, wr2_data_in;

   logic rsp_valid_ff, rsp_valid_in;
   spf_pkg::rsp_type rsp_ff, rsp_in;

   logic rx_wr_en, tx_wr_en;
   logic [AW-1:0] rx_wr_addr, tx_wr_addr;
   logic [spf_pkg::BYTE_W-1:0] rx_wr_data, tx_wr_data;
   logic [spf_pkg::BYTE_W-1:0] rx_q_a, rx_q_b, tx_q_a;

   logic [AW-1:0] rx_head_p1, rx_head_p2, rx_tail_p1, rx_tail_p2;
   logic [AW-1:0] tx_head_p1, tx_tail_p1, tx_tail_p2;
   logic [FW+spf_pkg::LINES_W-1:0] lines_wide;

   assign rx_head_p1 = addr_inc(rx_head_ff);
   assign rx_head_p2 = addr_inc(rx_head_p1);
   assign rx_tail_p1 = addr_inc(rx_tail_ff);
   assign rx_tail_p2 = addr_inc(rx_tail_p1);
   assign tx_head_p1 = addr_inc(tx_head_ff);
   assign tx_tail_p1 = addr_inc(tx_tail_ff);
   assign tx_tail_p2 = addr_inc(tx_tail_p1);

   spf_byte_ram #(.DEPTH(FIFO_DEPTH), .ADDR_W(AW)) u_rx_ram (
      .clock     (clock),
      .wr_en     (rx_wr_en),
      .wr_addr   (rx_wr_addr),
      .wr_data   (rx_wr_data),
      .rd_addr_a (rx_head_ff),
      .rd_addr_b (rx_head_p1),
      .rd_data_a (rx_q_a),
      .rd_data_b (rx_q_b)
   );

   spf_byte_ram #(.DEPTH(FIFO_DEPTH), .ADDR_W(AW)) u_tx_ram (
      .clock     (clock),
      .wr_en     (tx_wr_en),
      .wr_addr   (tx_wr_addr),
      .wr_data   (tx_wr_data),
      .rd_addr_a (tx_head_ff),
      .rd_addr_b (tx_head_ff),
      .rd_data_a (tx_q_a),
      .rd_data_b ()
   );

   always_comb begin
      state_in    = state_ff;
      rx_head_in  = rx_head_ff;
      rx_tail_in  = rx_tail_ff;
      rx_fill_in  = rx_fill_ff;
      tx_head_in  = tx_head_ff;
      tx_tail_in  = tx_tail_ff;
      tx_fill_in  = tx_fill_ff;
      line_cnt_in = line_cnt_ff;
      pop_lo_in   = pop_lo_ff;
      pop_hi_in   = pop_hi_ff;
      drain_in    = drain_ff;
      dropped_in  = dropped_ff;
      wr2_en_in   = 1'b0;
      wr2_tx_in   = wr2_tx_ff;
      wr2_addr_in = wr2_addr_ff;
      wr2_data_in = wr2_data_ff;
      rsp_valid_in = 1'b0;
      rsp_in      = rsp_ff;
      rx_wr_en    = 1'b0;
      rx_wr_addr  = rx_tail_ff;
      rx_wr_data  = req_data.host_byte;
      tx_wr_en    = 1'b0;
      tx_wr_addr  = tx_tail_ff;
      tx_wr_data  = req_data.write_value[spf_pkg::BYTE_W-1:0];
      lines_wide  = '0;

      unique case (state_ff)
         spf_pkg::ST_IDLE: begin
            if (start) begin
               state_in   = spf_pkg::ST_EXEC;
               pop_lo_in  = 1'b0;
               pop_hi_in  = 1'b0;
               drain_in   = 1'b0;
               dropped_in = 1'b0;
               unique case (req_data.func)
                  spf_pkg::FUNC_CPU_READ: begin
                     if (rx_fill_ff != '0) begin
                        pop_lo_in = 1'b1;
                        if (req_data.word_access && rx_fill_ff >= FILL_TWO) begin
                           pop_hi_in  = 1'b1;
                           rx_head_in = rx_head_p2;
                           rx_fill_in = rx_fill_ff - FILL_TWO;
                        end else begin
                           rx_head_in = rx_head_p1;
                           rx_fill_in = rx_fill_ff - FILL_ONE;
                        end
                     end
                  end
                  spf_pkg::FUNC_CPU_WRITE: begin
                     if (req_data.word_access ? (tx_fill_ff < FILL_FULL_M1)
                                              : (tx_fill_ff < FILL_FULL)) begin
                        tx_wr_en = 1'b1;
                        if (req_data.word_access) begin
                           wr2_en_in   = 1'b1;
                           wr2_tx_in   = 1'b1;
                           wr2_addr_in = tx_tail_p1;
                           wr2_data_in = req_data.write_value[spf_pkg::WORD_W-1:
                                                             spf_pkg::BYTE_W];
                           tx_tail_in  = tx_tail_p2;
                           tx_fill_in  = tx_fill_ff + FILL_TWO;
                        end else begin
                           tx_tail_in = tx_tail_p1;
                           tx_fill_in = tx_fill_ff + FILL_ONE;
                        end
                        if (req_data.write_value == spf_pkg::NEWLINE_WORD) begin
                           line_cnt_in = line_cnt_ff + FILL_ONE;
                        end
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  spf_pkg::FUNC_HOST_SEND: begin
                     if (rx_fill_ff < FILL_FULL) begin
                        rx_wr_en = 1'b1;
                        if (req_data.host_end_of_message && rx_fill_ff < FILL_FULL_M1) begin
                           wr2_en_in   = 1'b1;
                           wr2_tx_in   = 1'b0;
                           wr2_addr_in = rx_tail_p1;
                           wr2_data_in = spf_pkg::NEWLINE_BYTE;
                           rx_tail_in  = rx_tail_p2;
                           rx_fill_in  = rx_fill_ff + FILL_TWO;
                        end else begin
                           dropped_in = req_data.host_end_of_message;
                           rx_tail_in = rx_tail_p1;
                           rx_fill_in = rx_fill_ff + FILL_ONE;
                        end
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  spf_pkg::FUNC_HOST_DRAIN: begin
                     if (line_cnt_ff != '0 && tx_fill_ff != '0) begin
                        drain_in   = 1'b1;
                        tx_head_in = tx_head_p1;
                        tx_fill_in = tx_fill_ff - FILL_ONE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         spf_pkg::ST_EXEC: begin
            state_in = spf_pkg::ST_IDLE;
            if (wr2_en_ff) begin
               if (wr2_tx_ff) begin
                  tx_wr_en   = 1'b1;
                  tx_wr_addr = wr2_addr_ff;
                  tx_wr_data = wr2_data_ff;
               end else begin
                  rx_wr_en   = 1'b1;
                  rx_wr_addr = wr2_addr_ff;
                  rx_wr_data = wr2_data_ff;
               end
            end
            if (drain_ff && tx_q_a == spf_pkg::NEWLINE_BYTE) begin
               line_cnt_in = line_cnt_ff - FILL_ONE;
            end
            lines_wide = {{spf_pkg::LINES_W{1'b0}}, line_cnt_in};
            rsp_valid_in = 1'b1;
            rsp_in.read_data        = {pop_hi_ff ? rx_q_b : spf_pkg::ZERO_BYTE,
                                       pop_lo_ff ? rx_q_a : spf_pkg::ZERO_BYTE};
            rsp_in.drained_byte     = drain_ff ? tx_q_a : spf_pkg::ZERO_BYTE;
            rsp_in.drained_valid    = drain_ff;
            rsp_in.drained_line_end = drain_ff && (tx_q_a == spf_pkg::NEWLINE_BYTE);
            rsp_in.lines_waiting    = lines_wide[spf_pkg::LINES_W-1:0];
            rsp_in.write_dropped    = dropped_ff;
         end
         default: begin
            state_in = spf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spf_pkg::ST_IDLE;
         rx_head_ff   <= '0;
         rx_tail_ff   <= '0;
         rx_fill_ff   <= '0;
         tx_head_ff   <= '0;
         tx_tail_ff   <= '0;
         tx_fill_ff   <= '0;
         line_cnt_ff  <= '0;
         pop_lo_ff    <= 1'b0;
         pop_hi_ff    <= 1'b0;
         drain_ff     <= 1'b0;
         dropped_ff   <= 1'b0;
         wr2_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rx_head_ff   <= rx_head_in;
         rx_tail_ff   <= rx_tail_in;
         rx_fill_ff   <= rx_fill_in;
         tx_head_ff   <= tx_head_in;
         tx_tail_ff   <= tx_tail_in;
         tx_fill_ff   <= tx_fill_in;
         line_cnt_ff  <= line_cnt_in;
         pop_lo_ff    <= pop_lo_in;
         pop_hi_ff    <= pop_hi_in;
         drain_ff     <= drain_in;
         dropped_ff   <= dropped_in;
         wr2_en_ff    <= wr2_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      wr2_tx_ff   <= wr2_tx_in;
      wr2_addr_ff <= wr2_addr_in;
      wr2_data_ff <= wr2_data_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != spf_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/spf_byte_ram.sv */
`timescale 1ns / 1ps
// byte memory with one write port and two registered read ports
// uses spf_pkg for the byte width

module spf_byte_ram #(
   parameter int DEPTH = 4,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [spf_pkg::BYTE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]          rd_addr_a,
   input  logic [ADDR_W-1:0]          rd_addr_b,
   output logic [spf_pkg::BYTE_W-1:0] rd_data_a,
   output logic [spf_pkg::BYTE_W-1:0] rd_data_b
);

   logic [spf_pkg::BYTE_W-1:0] mem [DEPTH];
   logic [spf_pkg::BYTE_W-1:0] rd_a_ff;
   logic [spf_pkg::BYTE_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* rtl/spf_checker.sv */
`timescale 1ns / 1ps
// port-level checks for serial_port_byte_word_fifos, attached by bind
// uses spf_pkg for the result type

module spf_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input spf_pkg::rsp_type rsp_data
);

   // each transfer in gives its result once the execute state has passed and the result strobe is registered
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("result missing two cycles after request transfer");

   // no result without a request transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without request transfer");

   // block is busy for the cycle after a request transfer
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("not busy after request transfer");

   // a line end only comes with a drained byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.drained_line_end) |-> rsp_data.drained_valid)
      else $error("line end without drained byte");

   // no drained byte means a zero byte field
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.drained_valid) |-> (rsp_data.drained_byte == '0))
      else $error("drained byte nonzero without drain");

endmodule

bind serial_port_byte_word_fifos spf_checker u_spf_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
